// ===== rtl/rsps_pkg.sv =====
// Shared types, constants and the arctangent step table of the ring sector pixel shader.
package rsps_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int FILL_BITS      = 17;
  localparam int COLOR_BITS     = 32;
  localparam int LINE_BITS      = 13;
  localparam int INDEX_BITS     = 24;
  localparam int OUT_ITEM_BITS  = 1 + INDEX_BITS + COLOR_BITS;

  localparam logic [LINE_BITS-1:0] LINE_WIDTH_RST = 13'd1024;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KNOB_SIZE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_VALUE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_COLOR = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH = 3'd5;

  // The inner ring edge sits at 0.55 of the radius, so the squared ratio is 0.3025.
  localparam int RING_OUTER_SCALE = 10000;
  localparam int RING_INNER_SCALE = 3025;

  localparam int CORDIC_STEPS     = 28;
  localparam int PRE_SHIFT        = 16;
  localparam int FILL_SCALE_SHIFT = 16;

  // Angles in 1/2^32 turn.
  localparam logic [31:0] TURN_ZERO           = 32'h0000_0000;
  localparam logic [31:0] TURN_QUARTER        = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF           = 32'h8000_0000;
  localparam logic [31:0] TURN_THREE_QUARTERS = 32'hC000_0000;

  typedef struct packed {
    logic                  axis;
    logic                  we;
    logic [INDEX_BITS-1:0] index;
  } side_t;

  function automatic logic [31:0] step_angle(input int idx);
    logic [31:0] ang;
    case (idx)
      0:  ang = 32'd536870912;
      1:  ang = 32'd316933406;
      2:  ang = 32'd167458907;
      3:  ang = 32'd85004756;
      4:  ang = 32'd42667331;
      5:  ang = 32'd21354465;
      6:  ang = 32'd10679838;
      7:  ang = 32'd5340245;
      8:  ang = 32'd2670163;
      9:  ang = 32'd1335087;
      10: ang = 32'd667544;
      11: ang = 32'd333772;
      12: ang = 32'd166886;
      13: ang = 32'd83443;
      14: ang = 32'd41722;
      15: ang = 32'd20861;
      16: ang = 32'd10430;
      17: ang = 32'd5215;
      18: ang = 32'd2608;
      19: ang = 32'd1304;
      20: ang = 32'd652;
      21: ang = 32'd326;
      22: ang = 32'd163;
      23: ang = 32'd81;
      24: ang = 32'd41;
      25: ang = 32'd20;
      26: ang = 32'd10;
      27: ang = 32'd5;
      default: ang = 32'd0;
    endcase
    return ang;
  endfunction

endpackage

// ===== rtl/rsps_front.sv =====
// Front pipeline: window test, squared radius, ring test, quadrant fold and row-major address.
module rsps_front #(
  parameter int COORD_BITS = rsps_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              adv,
  input  logic                                              in_valid,
  input  logic [COORD_BITS-1:0]                             pixel_x,
  input  logic [COORD_BITS-1:0]                             pixel_y,
  input  logic [COORD_BITS-1:0]                             center_x,
  input  logic [COORD_BITS-1:0]                             center_y,
  input  logic [COORD_BITS-1:0]                             knob_size,
  input  logic [rsps_pkg::LINE_BITS-1:0]                    line_width,
  output logic                                              valid_o,
  output logic signed [COORD_BITS+rsps_pkg::PRE_SHIFT+2:0]  x_o,
  output logic signed [COORD_BITS+rsps_pkg::PRE_SHIFT+2:0]  y_o,
  output logic [31:0]                                       z_o,
  output rsps_pkg::side_t                                   side_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int XW  = COORD_BITS + rsps_pkg::PRE_SHIFT + 3;
  localparam int SQW = 2 * COORD_BITS;
  localparam int RW  = SQW + 1;
  localparam int QW  = SQW - 2;
  localparam int CW  = RW + 14;
  localparam int PW  = COORD_BITS + rsps_pkg::LINE_BITS;
  localparam int AW  = (PW > rsps_pkg::INDEX_BITS ? PW : rsps_pkg::INDEX_BITS) + 1;

  // Ring bounds follow the knob size; q_r and then q_scaled_r are registered from it in turn.
  logic [SQW-1:0] ks_sq;
  logic [QW-1:0]  q_r;
  logic [CW-1:0]  q_scaled_r;

  assign ks_sq = SQW'(knob_size) * SQW'(knob_size);

  always_ff @(posedge clk) begin
    q_r        <= ks_sq[SQW-1:2];
    q_scaled_r <= CW'(q_r) * CW'(rsps_pkg::RING_INNER_SCALE);
  end

  // Stage 1: offsets from the center and the scan window.
  logic signed [DW-1:0] dx_c, dy_c, h_s;
  logic                 win_c;

  assign dx_c  = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x});
  assign dy_c  = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y});
  assign h_s   = $signed({2'b00, knob_size[COORD_BITS-1:1]});
  assign win_c = (dx_c >= -h_s) && (dx_c < h_s) && (dy_c >= -h_s) && (dy_c <= h_s);

  logic                  v1_r;
  logic signed [DW-1:0]  dx1_r, dy1_r;
  logic [COORD_BITS-1:0] px1_r, py1_r;
  logic                  win1_r;

  // Stage 2: squares, row product and quadrant fold.
  logic signed [2*DW-1:0] dxx, dyy;
  logic [PW-1:0]          prod_c;
  logic signed [DW-1:0]   ndx, ndy;
  logic                   axis_c;
  logic [31:0]            base_c;
  logic [COORD_BITS-1:0]  p_c, q_c;

  assign dxx    = dx1_r * dx1_r;
  assign dyy    = dy1_r * dy1_r;
  assign prod_c = PW'(py1_r) * PW'(line_width);
  assign ndx    = -dx1_r;
  assign ndy    = -dy1_r;

  // Rows grow downward, so "up" is the negated row offset.
  always_comb begin
    axis_c = 1'b0;
    base_c = rsps_pkg::TURN_ZERO;
    p_c    = '0;
    q_c    = '0;
    if (dy1_r == '0) begin
      axis_c = 1'b1;
      base_c = (dx1_r > 0) ? rsps_pkg::TURN_QUARTER : rsps_pkg::TURN_THREE_QUARTERS;
    end else if (dx1_r == '0) begin
      axis_c = 1'b1;
      base_c = (dy1_r > 0) ? rsps_pkg::TURN_HALF : rsps_pkg::TURN_ZERO;
    end else if (dx1_r > 0 && dy1_r < 0) begin
      p_c = dx1_r[COORD_BITS-1:0];
      q_c = ndy[COORD_BITS-1:0];
    end else if (dx1_r > 0) begin
      base_c = rsps_pkg::TURN_QUARTER;
      p_c    = dy1_r[COORD_BITS-1:0];
      q_c    = dx1_r[COORD_BITS-1:0];
    end else if (dy1_r > 0) begin
      base_c = rsps_pkg::TURN_HALF;
      p_c    = ndx[COORD_BITS-1:0];
      q_c    = dy1_r[COORD_BITS-1:0];
    end else begin
      base_c = rsps_pkg::TURN_THREE_QUARTERS;
      p_c    = ndy[COORD_BITS-1:0];
      q_c    = ndx[COORD_BITS-1:0];
    end
  end

  logic                  v2_r;
  logic [SQW-1:0]        sqx2_r, sqy2_r;
  logic [PW-1:0]         prod2_r;
  logic [COORD_BITS-1:0] px2_r;
  logic                  win2_r, axis2_r;
  logic [31:0]           base2_r;
  logic [COORD_BITS-1:0] p2_r, q2_r;

  // Stage 3: radius sum, address and vector setup.
  logic [AW-1:0] addr_c;

  assign addr_c = AW'(px2_r) + AW'(prod2_r);

  logic                                   v3_r;
  logic [RW-1:0]                          r3_r;
  logic [rsps_pkg::INDEX_BITS-1:0]        idx3_r;
  logic signed [XW-1:0]                   x3_r, y3_r;
  logic [31:0]                            z3_r;
  logic                                   win3_r, axis3_r;

  // Stage 4: ring test against both edges.
  logic [CW-1:0] r_scaled;
  logic          ring_c;

  assign r_scaled = CW'(r3_r) * CW'(rsps_pkg::RING_OUTER_SCALE);
  assign ring_c   = (r3_r < RW'(q_r)) && (r_scaled > q_scaled_r);

  logic                 v4_r;
  logic signed [XW-1:0] x4_r, y4_r;
  logic [31:0]          z4_r;
  rsps_pkg::side_t      side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r   <= dx_c;
      dy1_r   <= dy_c;
      px1_r   <= pixel_x;
      py1_r   <= pixel_y;
      win1_r  <= win_c;

      sqx2_r  <= dxx[SQW-1:0];
      sqy2_r  <= dyy[SQW-1:0];
      prod2_r <= prod_c;
      px2_r   <= px1_r;
      win2_r  <= win1_r;
      axis2_r <= axis_c;
      base2_r <= base_c;
      p2_r    <= p_c;
      q2_r    <= q_c;

      r3_r    <= RW'(sqx2_r) + RW'(sqy2_r);
      idx3_r  <= addr_c[rsps_pkg::INDEX_BITS-1:0];
      x3_r    <= $signed({3'b000, q2_r, {rsps_pkg::PRE_SHIFT{1'b0}}});
      y3_r    <= $signed({3'b000, p2_r, {rsps_pkg::PRE_SHIFT{1'b0}}});
      z3_r    <= base2_r;
      win3_r  <= win2_r;
      axis3_r <= axis2_r;

      x4_r          <= x3_r;
      y4_r          <= y3_r;
      z4_r          <= z3_r;
      side4_r.axis  <= axis3_r;
      side4_r.we    <= win3_r && ring_c;
      side4_r.index <= idx3_r;
    end
  end

  assign valid_o = v4_r;
  assign x_o     = x4_r;
  assign y_o     = y4_r;
  assign z_o     = z4_r;
  assign side_o  = side4_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && adv) |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v4_r) && $stable(side4_r.we))
    else $error("front pipeline moved while stalled");

endmodule

// ===== rtl/rsps_cell.sv =====
// One vectoring step of the angle chain: rotates toward the x axis and accumulates the angle.
module rsps_cell #(
  parameter int COORD_BITS = rsps_pkg::COORD_BITS_DEF,
  parameter int STEP       = 0
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              adv,
  input  logic                                              valid_i,
  input  logic signed [COORD_BITS+rsps_pkg::PRE_SHIFT+2:0]  x_i,
  input  logic signed [COORD_BITS+rsps_pkg::PRE_SHIFT+2:0]  y_i,
  input  logic [31:0]                                       z_i,
  input  rsps_pkg::side_t                                   side_i,
  output logic                                              valid_o,
  output logic signed [COORD_BITS+rsps_pkg::PRE_SHIFT+2:0]  x_o,
  output logic signed [COORD_BITS+rsps_pkg::PRE_SHIFT+2:0]  y_o,
  output logic [31:0]                                       z_o,
  output rsps_pkg::side_t                                   side_o
);

  localparam int          XW         = COORD_BITS + rsps_pkg::PRE_SHIFT + 3;
  localparam logic [31:0] STEP_ANGLE = rsps_pkg::step_angle(STEP);

  logic signed [XW-1:0] y_mag, x_sh, x_nxt, y_nxt;
  logic [31:0]          z_nxt;

  // The x leg stays positive; y is shifted by magnitude so it truncates toward zero.
  assign y_mag = y_i[XW-1] ? -y_i : y_i;
  assign x_sh  = x_i >>> STEP;
  assign x_nxt = x_i + (y_mag >> STEP);

  always_comb begin
    if (y_i > 0) begin
      y_nxt = y_i - x_sh;
      z_nxt = z_i + STEP_ANGLE;
    end else begin
      y_nxt = y_i + x_sh;
      z_nxt = z_i - STEP_ANGLE;
    end
    // Axis pixels already carry their final angle.
    if (side_i.axis) begin
      z_nxt = z_i;
    end
  end

  logic                 valid_r;
  logic signed [XW-1:0] x_r, y_r;
  logic [31:0]          z_r;
  rsps_pkg::side_t      side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

// ===== rtl/rsps_skid.sv =====
// Two-entry output buffer that decouples the pipeline from the result consumer.
module rsps_skid #(
  parameter int W = rsps_pkg::OUT_ITEM_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam logic [1:0] FULL = 2'd2;

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r, count_nxt;
  logic         pop;

  assign out_valid = (count_r != 2'd0);
  assign room      = (count_r != FULL);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != FULL) || pop)
    else $error("output buffer written while full");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 2'd1))
    else $error("output buffer count did not drop after a request left");

endmodule

// ===== rtl/ring_sector_pixel_shader.sv =====
// Top level of the ring sector pixel shader: configuration, angle chain, fill test, output buffer.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------------
//  in      | in_tvalid/in_tready   | in_tdata: pixel_x, pixel_y (low bits up)
//  out     | out_tvalid/out_tready | out_tdata: pixel_index, pixel_color; out_tuser: write_enable
//  cfg     | cfg_we (no wait)      | cfg_index selects the register, cfg_data holds the value
//
// One request is taken every clock while the output buffer has room; a result passes through
// four front stages, one cell per arctangent step (28) and one fill stage.
// The chain advances as a whole whenever the two-entry output buffer has room, so in_tready
// only drops while both buffer entries wait for the consumer.
// Reset is synchronous and clears the valid bits and the registers to their defaults.
module ring_sector_pixel_shader #(
  parameter int COORD_BITS = rsps_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rsps_pkg::ANGLE_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // pixel_x, pixel_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]                 in_tdata,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // pixel_index, pixel_color
  output logic [rsps_pkg::INDEX_BITS+rsps_pkg::COLOR_BITS-1:0] out_tdata,
  // write_enable
  output logic [0:0]                                        out_tuser,
  input  logic                                              cfg_we,
  input  logic [rsps_pkg::CFG_INDEX_BITS-1:0]               cfg_index,
  input  logic [rsps_pkg::CFG_DATA_BITS-1:0]                cfg_data
);

  localparam int XW = COORD_BITS + rsps_pkg::PRE_SHIFT + 3;
  localparam int NS = rsps_pkg::CORDIC_STEPS;
  localparam int FW = ANGLE_BITS + rsps_pkg::FILL_SCALE_SHIFT + 3;
  localparam logic signed [FW-1:0] FULL_TURN =
    FW'(1) <<< (ANGLE_BITS + rsps_pkg::FILL_SCALE_SHIFT);

  // Configuration registers.
  logic [COORD_BITS-1:0]                 center_x_r, center_y_r, knob_size_r;
  logic signed [rsps_pkg::FILL_BITS-1:0] fill_value_r;
  logic [rsps_pkg::COLOR_BITS-1:0]       fill_color_r;
  logic [rsps_pkg::LINE_BITS-1:0]        line_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      knob_size_r  <= '0;
      fill_value_r <= '0;
      fill_color_r <= '0;
      line_width_r <= rsps_pkg::LINE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsps_pkg::REG_CENTER_X:   center_x_r   <= cfg_data[COORD_BITS-1:0];
        rsps_pkg::REG_CENTER_Y:   center_y_r   <= cfg_data[COORD_BITS-1:0];
        rsps_pkg::REG_KNOB_SIZE:  knob_size_r  <= cfg_data[COORD_BITS-1:0];
        rsps_pkg::REG_FILL_VALUE: fill_value_r <= cfg_data[rsps_pkg::FILL_BITS-1:0];
        rsps_pkg::REG_FILL_COLOR: fill_color_r <= cfg_data[rsps_pkg::COLOR_BITS-1:0];
        rsps_pkg::REG_LINE_WIDTH: line_width_r <= cfg_data[rsps_pkg::LINE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign in_tready = adv;

  // Links of the chain; entry 0 comes from the front pipeline.
  logic                 vld_w  [0:NS];
  logic signed [XW-1:0] x_w    [0:NS];
  logic signed [XW-1:0] y_w    [0:NS];
  logic [31:0]          z_w    [0:NS];
  rsps_pkg::side_t      side_w [0:NS];

  rsps_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_tvalid),
    .pixel_x    (in_tdata[COORD_BITS-1:0]),
    .pixel_y    (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .center_x   (center_x_r),
    .center_y   (center_y_r),
    .knob_size  (knob_size_r),
    .line_width (line_width_r),
    .valid_o    (vld_w[0]),
    .x_o        (x_w[0]),
    .y_o        (y_w[0]),
    .z_o        (z_w[0]),
    .side_o     (side_w[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_cell
    rsps_cell #(
      .COORD_BITS (COORD_BITS),
      .STEP       (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (vld_w[g]),
      .x_i     (x_w[g]),
      .y_i     (y_w[g]),
      .z_i     (z_w[g]),
      .side_i  (side_w[g]),
      .valid_o (vld_w[g+1]),
      .x_o     (x_w[g+1]),
      .y_o     (y_w[g+1]),
      .z_o     (z_w[g+1]),
      .side_o  (side_w[g+1])
    );
  end

  // Fill test on the finished angle, both sides scaled to 2^-(ANGLE_BITS+16) turn.
  logic [ANGLE_BITS-1:0] angle_c;
  logic signed [FW-1:0]  a_scl, v_scl, rest_c;
  logic                  fill_c;

  assign angle_c = z_w[NS][31:32-ANGLE_BITS];
  assign a_scl   = $signed({3'b000, angle_c, {rsps_pkg::FILL_SCALE_SHIFT{1'b0}}});
  assign v_scl   = FW'(fill_value_r) <<< (ANGLE_BITS + 1);
  assign rest_c  = FULL_TURN - a_scl;
  assign fill_c  = (fill_value_r > 0) ? (a_scl < v_scl) : (rest_c <= -v_scl);

  logic                            fill_vld_r, fill_we_r;
  logic [rsps_pkg::INDEX_BITS-1:0] fill_idx_r;
  logic [rsps_pkg::COLOR_BITS-1:0] fill_color_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r <= 1'b0;
    end else if (adv) begin
      fill_vld_r <= vld_w[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fill_we_r        <= side_w[NS].we;
      fill_idx_r       <= side_w[NS].index;
      fill_color_out_r <= (side_w[NS].we && fill_c) ? fill_color_r : '0;
    end
  end

  logic [rsps_pkg::OUT_ITEM_BITS-1:0] skid_in, skid_out;

  assign skid_in = {fill_color_out_r, fill_idx_r, fill_we_r};

  rsps_skid #(
    .W (rsps_pkg::OUT_ITEM_BITS)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && fill_vld_r),
    .push_data (skid_in),
    .room      (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (skid_out)
  );

  assign out_tuser = skid_out[0];
  assign out_tdata = skid_out[rsps_pkg::OUT_ITEM_BITS-1:1];

  a_off_ring_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |->
      (out_tdata[rsps_pkg::INDEX_BITS+rsps_pkg::COLOR_BITS-1:rsps_pkg::INDEX_BITS] == '0))
    else $error("color given for a pixel that is not written");

  a_fill_black: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_vld_r && !fill_we_r) |-> (fill_color_out_r == '0))
    else $error("fill stage colored a pixel off the ring");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the ring sector pixel shader: directed knob cases, then random knobs.
module tb;

  localparam int CW             = rsps_pkg::COORD_BITS_DEF;
  localparam int AW             = rsps_pkg::ANGLE_BITS_DEF;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int CALM_ITEMS     = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;

  // Indexes past the last register; writes there must leave the knob unchanged.
  localparam logic [rsps_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rsps_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                            we;
    logic [rsps_pkg::INDEX_BITS-1:0] index;
    logic [rsps_pkg::COLOR_BITS-1:0] color;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // pixel_x, pixel_y
  logic [2*CW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b1;
  // pixel_index, pixel_color
  logic [rsps_pkg::INDEX_BITS+rsps_pkg::COLOR_BITS-1:0] out_tdata;
  // write_enable
  logic [0:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [rsps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [rsps_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // Knob registers as the shader should hold them.
  logic [CW-1:0] knob_cx = '0;
  logic [CW-1:0] knob_cy = '0;
  logic [CW-1:0] knob_diam = '0;
  logic signed [rsps_pkg::FILL_BITS-1:0] arc_fill = '0;
  logic [rsps_pkg::COLOR_BITS-1:0] arc_color = '0;
  logic [rsps_pkg::LINE_BITS-1:0] row_len = rsps_pkg::LINE_WIDTH_RST;

  shade_t pending_shades[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic allow_idle = 1'b1;

  ring_sector_pixel_shader dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint arc_step_turns(input int i);
    case (i)
      0:  return 536870912;  1:  return 316933406;  2:  return 167458907;  3:  return 85004756;
      4:  return 42667331;   5:  return 21354465;   6:  return 10679838;   7:  return 5340245;
      8:  return 2670163;    9:  return 1335087;    10: return 667544;     11: return 333772;
      12: return 166886;     13: return 83443;      14: return 41722;      15: return 20861;
      16: return 10430;      17: return 5215;       18: return 2608;       19: return 1304;
      20: return 652;        21: return 326;        22: return 163;        23: return 81;
      24: return 41;         25: return 20;         26: return 10;         27: return 5;
      default: return 0;
    endcase
  endfunction

  // Clockwise angle from the top in 1/2^AW turn; up points toward smaller rows.
  function automatic logic [AW-1:0] ring_angle(input longint dx, input longint up);
    longint base, p, q, vx, vy, xs, z;
    logic [63:0] total;
    int i;
    z = 0;
    if (up == 0)
      return (dx > 0) ? rsps_pkg::TURN_QUARTER[31:32-AW]
                      : rsps_pkg::TURN_THREE_QUARTERS[31:32-AW];
    if (dx == 0)
      return (up < 0) ? rsps_pkg::TURN_HALF[31:32-AW] : rsps_pkg::TURN_ZERO[31:32-AW];
    if (dx > 0 && up > 0) begin
      base = longint'(rsps_pkg::TURN_ZERO); p = dx; q = up;
    end else if (dx > 0) begin
      base = longint'(rsps_pkg::TURN_QUARTER); p = -up; q = dx;
    end else if (up < 0) begin
      base = longint'(rsps_pkg::TURN_HALF); p = -dx; q = -up;
    end else begin
      base = longint'(rsps_pkg::TURN_THREE_QUARTERS); p = up; q = -dx;
    end
    vx = q <<< rsps_pkg::PRE_SHIFT;
    vy = p <<< rsps_pkg::PRE_SHIFT;
    for (i = 0; i < rsps_pkg::CORDIC_STEPS; i++) begin
      xs = vx >>> i;
      if (vy > 0) begin
        vx += vy >>> i;
        vy -= xs;
        z += arc_step_turns(i);
      end else begin
        vx += (-vy) >>> i;
        vy += xs;
        z -= arc_step_turns(i);
      end
    end
    total = base + z;
    return total[31:32-AW];
  endfunction

  function automatic shade_t shade_pixel(input logic [CW-1:0] px, input logic [CW-1:0] py);
    longint x, y, cx, cy, h, dx, dy, r, q, v, a, vv;
    logic [63:0] addr;
    logic [AW-1:0] ang;
    shade_t res;
    x = longint'(px);
    y = longint'(py);
    cx = longint'(knob_cx);
    cy = longint'(knob_cy);
    h = longint'(knob_diam) / 2;
    dx = x - cx;
    dy = y - cy;
    r = dx * dx + dy * dy;
    q = (longint'(knob_diam) * longint'(knob_diam)) >>> 2;
    // The window is half-open in x but closed in y.
    res.we = (x >= cx - h) && (x < cx + h) && (y >= cy - h) && (y <= cy + h)
          && (r < q) && (r * rsps_pkg::RING_OUTER_SCALE > q * rsps_pkg::RING_INNER_SCALE);
    addr = x + y * longint'(row_len);
    res.index = addr[rsps_pkg::INDEX_BITS-1:0];
    res.color = '0;
    if (res.we) begin
      ang = ring_angle(dx, -dy);
      v = longint'(arc_fill);
      a = longint'(ang) <<< rsps_pkg::FILL_SCALE_SHIFT;
      vv = v <<< (AW + 1);
      if ((v > 0) ? (a < vv) : (((longint'(1)) <<< (AW + 16)) - a <= -vv))
        res.color = arc_color;
    end
    return res;
  endfunction

  task automatic write_reg(input logic [rsps_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsps_pkg::REG_CENTER_X:   knob_cx = value[CW-1:0];
      rsps_pkg::REG_CENTER_Y:   knob_cy = value[CW-1:0];
      rsps_pkg::REG_KNOB_SIZE:  knob_diam = value[CW-1:0];
      rsps_pkg::REG_FILL_VALUE: arc_fill = value[rsps_pkg::FILL_BITS-1:0];
      rsps_pkg::REG_FILL_COLOR: arc_color = value;
      rsps_pkg::REG_LINE_WIDTH: row_len = value[rsps_pkg::LINE_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_knob(input int cx, input int cy, input int diam, input int fill,
                          input logic [31:0] color, input int line);
    write_reg(rsps_pkg::REG_CENTER_X, 32'(cx));
    write_reg(rsps_pkg::REG_CENTER_Y, 32'(cy));
    write_reg(rsps_pkg::REG_KNOB_SIZE, 32'(diam));
    write_reg(rsps_pkg::REG_FILL_VALUE, 32'(fill));
    write_reg(rsps_pkg::REG_FILL_COLOR, color);
    write_reg(rsps_pkg::REG_LINE_WIDTH, 32'(line));
  endtask

  // Leaves in_tvalid high after the accepting edge so back-to-back requests need no gap.
  task automatic send_pixel(input logic [CW-1:0] px, input logic [CW-1:0] py);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_shades.push_back(shade_pixel(px, py));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  task automatic test_reset_defaults();
    // Size zero after reset: no pixel is ever on the ring.
    send_pixel('0, '0);
    send_pixel('1, '1);
    wait_drained();
  endtask

  task automatic test_axis_angles();
    // Odd size 101: the ring reaches past the right window border but not the left one.
    set_knob(200, 300, 101, 16384, 32'hA5A5_5A5A, 640);
    send_pixel(240, 300);
    send_pixel(160, 300);
    send_pixel(200, 260);
    send_pixel(200, 340);
    send_pixel(150, 300);
    send_pixel(250, 300);
    send_pixel(200, 350);
    send_pixel(225, 325);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    set_knob(4095, 4095, 4095, 32768, 32'hFFFF_FFFF, 8191);
    // Address wraps past 24 bits here.
    send_pixel(2048, 4095);
    send_pixel(0, 0);
    wait_drained();
    write_reg(rsps_pkg::REG_LINE_WIDTH, 32'd0);
    send_pixel(4095, 4095);
    wait_drained();
    write_reg(rsps_pkg::REG_LINE_WIDTH, 32'd4096);
    send_pixel(2048, 4095);
    wait_drained();
  endtask

  task automatic test_fill_direction();
    int fills[5];
    int k;
    // Full turns both ways, fill values past the legal range, and a quarter counterclockwise.
    fills = '{32768, -32768, 65535, -65536, -8192};
    set_knob(1000, 2000, 40, 0, 32'h1234_5678, 1);
    for (k = 0; k < 5; k++) begin
      write_reg(rsps_pkg::REG_FILL_VALUE, 32'(fills[k]));
      send_pixel(1010, 1990);
      send_pixel(990, 1990);
      wait_drained();
    end
  endtask

  task automatic test_unused_registers();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_pixel(1010, 2010);
    wait_drained();
  endtask

  task automatic test_random_knobs();
    int sent, batch, k, h, px, py, cx, cy, diam, fill, line;
    logic [31:0] color;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Toward the end both sides run without gaps.
      allow_idle <= (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 7))
        0: cx = 0;
        1: cx = 4095;
        2: cx = $urandom;
        default: cx = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 7))
        0: cy = 0;
        1: cy = 4095;
        2: cy = $urandom;
        default: cy = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 9))
        0: diam = $urandom_range(0, 3);
        1: diam = ($urandom_range(0, 1) == 0) ? 4095 : $urandom_range(2048, 4095);
        default: diam = $urandom_range(4, 160);
      endcase
      case ($urandom_range(0, 9))
        0: fill = 32768;
        1: fill = -32768;
        2: fill = 0;
        3: fill = $urandom;
        default: fill = $urandom_range(0, 65536) - 32768;
      endcase
      case ($urandom_range(0, 7))
        0: color = '0;
        1: color = '1;
        default: color = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: line = 0;
        1: line = 8191;
        2: line = 1;
        3: line = 4096;
        4: line = $urandom;
        default: line = $urandom_range(1, 4096);
      endcase
      set_knob(cx, cy, diam, fill, color, line);
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      batch = $urandom_range(30, 110);
      h = int'(knob_diam) / 2;
      for (k = 0; k < batch; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          px = $urandom;
          py = $urandom;
        end else begin
          // Just around the bounding box, so the window and ring borders are hit often.
          px = int'(knob_cx) - h - 1 + int'($urandom_range(0, int'(knob_diam) + 2));
          py = int'(knob_cy) - h - 1 + int'($urandom_range(0, int'(knob_diam) + 2));
        end
        send_pixel(px[CW-1:0], py[CW-1:0]);
      end
      sent += batch;
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || !allow_idle) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(1, 3));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    shade_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_shades.size() == 0) begin
        note_mismatch("result with no request pending", '0, 64'({out_tuser, out_tdata}));
      end else begin
        want = pending_shades.pop_front();
        if (out_tuser[0] !== want.we)
          note_mismatch("write_enable", 64'(want.we), 64'(out_tuser[0]));
        if (out_tdata[rsps_pkg::INDEX_BITS-1:0] !== want.index)
          note_mismatch("pixel_index", 64'(want.index),
                        64'(out_tdata[rsps_pkg::INDEX_BITS-1:0]));
        if (out_tdata[rsps_pkg::INDEX_BITS +: rsps_pkg::COLOR_BITS] !== want.color)
          note_mismatch("pixel_color", 64'(want.color),
                        64'(out_tdata[rsps_pkg::INDEX_BITS +: rsps_pkg::COLOR_BITS]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_axis_angles();
    test_field_extremes();
    test_fill_direction();
    test_unused_registers();
    test_random_knobs();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_shades.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rsps_pkg.sv
rtl/rsps_front.sv
rtl/rsps_cell.sv
rtl/rsps_skid.sv
rtl/ring_sector_pixel_shader.sv
tb/tb.sv
